[sv/urrg_pkg.sv]
// urrg_pkg: shared types and constants for the uniform random range generator
// request and result payloads, command codes, queue entry layout
// no dependencies
package urrg_pkg;

  localparam logic [31:0] LCG_MUL    = 32'd69069;
  localparam logic [31:0] LCG_INC    = 32'd1;
  localparam logic [31:0] SEED_SUBST = 32'd259341593;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] SMAX       = 32'h7FFF_FFFF;

  localparam int MANT_LSB  = 9;
  localparam int MANT_W    = 23;
  localparam int SPAN_W    = 33;
  localparam int PROD_W    = SPAN_W + MANT_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int FRAC_W    = 2 * MANT_W;
  localparam int QHI_W     = SUM_W - MANT_W;
  localparam int SUMHI_W   = SUM_W - FRAC_W;
  localparam int IP_W      = 36;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_FULL     = 2'd1,
    CMD_SIGNED   = 2'd2,
    CMD_UNSIGNED = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] seed_out;
  } res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        pass;
    logic        noclamp;
    logic        flip;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] seed;
  } job_t;

endpackage

[sv/urrg_front.sv]
// urrg_front: accepts requests, resolves range bounds and advances the seed
// depends on urrg_pkg
module urrg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  urrg_pkg::req_t req,
  output logic          full,
  input  logic          q_full,
  output logic          enq,
  output urrg_pkg::job_t job
);
  import urrg_pkg::*;

  logic [31:0] seed;
  logic [31:0] seed_next;
  logic [31:0] seed_cur;
  logic [31:0] seed_adv;
  logic [31:0] lo;
  logic [31:0] hi;
  logic        is_load;
  logic        is_draw;
  logic        is_uns;
  logic        no_span;
  logic        advance;

  assign full = q_full;
  assign enq  = push & ~q_full;

  assign seed_cur = (seed == 32'd0) ? SEED_SUBST : seed;
  assign seed_adv = 32'(seed_cur * LCG_MUL) + LCG_INC;

  always_comb begin
    is_load = 1'b0;
    is_uns  = 1'b0;
    lo      = 32'd0;
    hi      = 32'd0;
    unique case (req.cmd)
      CMD_LOAD: begin
        is_load = 1'b1;
      end
      CMD_FULL: begin
        lo = SIGN_BIT;
        hi = SMAX;
      end
      CMD_SIGNED: begin
        lo = req.operand_a;
        hi = req.operand_b;
      end
      CMD_UNSIGNED: begin
        is_uns = 1'b1;
        if (req.operand_a < req.operand_b) begin
          lo = req.operand_a ^ SIGN_BIT;
          hi = req.operand_b ^ SIGN_BIT;
        end else begin
          lo = req.operand_b ^ SIGN_BIT;
          hi = req.operand_a ^ SIGN_BIT;
        end
      end
      default: begin
        is_load = 1'b1;
      end
    endcase
    is_draw = ~is_load;
    no_span = $signed(lo) >= $signed(hi);
    advance = is_draw & ~no_span;
    if (is_load) begin
      seed_next = req.operand_a;
    end else if (advance) begin
      seed_next = seed_adv;
    end else begin
      seed_next = seed;
    end
  end

  always_comb begin
    job.pass    = is_load | no_span;
    job.noclamp = (lo == SIGN_BIT) & (hi == SMAX);
    job.flip    = is_uns;
    job.lo      = lo;
    job.hi      = hi;
    job.seed    = seed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (enq) begin
      seed <= seed_next;
    end
  end

endmodule

[sv/urrg_queue.sv]
// urrg_queue: short queue of classified requests between front and back
// depends on urrg_pkg
module urrg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          enq,
  input  urrg_pkg::job_t enq_job,
  output logic          q_full,
  input  logic          deq,
  output logic          q_vld,
  output urrg_pkg::job_t q_job
);
  import urrg_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;

  assign q_full = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign q_vld  = count != '0;
  assign q_job  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wptr <= wptr + 1'b1;
      end
      if (deq) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      entries[wptr] <= enq_job;
    end
  end

endmodule

[sv/urrg_back.sv]
// urrg_back: six-stage pipeline that scales the span by the seed fraction,
// rounds, clamps and registers the result; depends on urrg_pkg
module urrg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_vld,
  input  urrg_pkg::job_t q_job,
  output logic          deq,
  input  logic          pop,
  output logic          res_vld,
  output urrg_pkg::res_t res
);
  import urrg_pkg::*;

  logic [5:0]          vld;
  logic [5:0]          take;
  logic [5:0]          leave;
  job_t                jb [5];

  logic [SPAN_W-1:0]   span1;
  logic [SPAN_W-1:0]   span2;
  logic [PROD_W-1:0]   y2;
  logic [PROD_W-1:0]   y3;
  logic [SUM_W-1:0]    x3;
  logic [QHI_W-1:0]    xhi4;
  logic [SUMHI_W-1:0]  sumhi4;
  logic                remnz4;
  logic [IP_W-1:0]     ip5;
  logic                remnz5;

  logic [SPAN_W-1:0]   span_c;
  logic [SUM_W-1:0]    sum_c;
  logic [IP_W-1:0]     ip_c;
  logic [IP_W-1:0]     adj_c;
  logic [IP_W-1:0]     lo_c;
  logic [IP_W-1:0]     hi_c;
  logic [31:0]         val_c;
  res_t                res_c;

  assign deq     = take[0];
  assign res_vld = vld[5];

  always_comb begin
    leave[5] = vld[5] & pop;
    for (int k = 4; k >= 0; k--) begin
      leave[k] = vld[k] & (~vld[k+1] | leave[k+1]);
    end
    take[0] = q_vld & (~vld[0] | leave[0]);
    for (int k = 1; k < 6; k++) begin
      take[k] = leave[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= take | (vld & ~leave);
    end
  end

  assign span_c = {q_job.hi[31], q_job.hi} - {q_job.lo[31], q_job.lo} + SPAN_W'(1);
  assign sum_c  = SUM_W'({x3[MANT_W-1:0], {MANT_W{1'b0}}}) + SUM_W'(y3);
  assign ip_c   = IP_W'(xhi4) + IP_W'(sumhi4) + {{(IP_W-32){jb[3].lo[31]}}, jb[3].lo};

  always_comb begin
    lo_c  = {{(IP_W-32){jb[4].lo[31]}}, jb[4].lo};
    hi_c  = {{(IP_W-32){jb[4].hi[31]}}, jb[4].hi};
    adj_c = ip5;
    if (ip5[IP_W-1] && !remnz5) begin
      adj_c = ip5 - IP_W'(1);
    end
    if (!jb[4].noclamp) begin
      if ($signed(adj_c) < $signed(lo_c)) begin
        adj_c = lo_c;
      end else if ($signed(adj_c) > $signed(hi_c)) begin
        adj_c = hi_c;
      end
    end
    val_c = jb[4].pass ? jb[4].lo : adj_c[31:0];
    res_c.value    = val_c ^ (jb[4].flip ? SIGN_BIT : 32'd0);
    res_c.seed_out = jb[4].seed;
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      jb[0] <= q_job;
      span1 <= span_c;
    end
    if (take[1]) begin
      jb[1] <= jb[0];
      span2 <= span1;
      y2    <= PROD_W'(span1) * PROD_W'(jb[0].seed[31:MANT_LSB]);
    end
    if (take[2]) begin
      jb[2] <= jb[1];
      y3    <= y2;
      x3    <= SUM_W'(y2) + SUM_W'(span2);
    end
    if (take[3]) begin
      jb[3]  <= jb[2];
      xhi4   <= x3[SUM_W-1:MANT_W];
      sumhi4 <= sum_c[SUM_W-1:FRAC_W];
      remnz4 <= |sum_c[FRAC_W-1:0];
    end
    if (take[4]) begin
      jb[4]  <= jb[3];
      ip5    <= ip_c;
      remnz5 <= remnz4;
    end
    if (take[5]) begin
      res <= res_c;
    end
  end

endmodule

[sv/uniform_random_range_generator.sv]
// uniform_random_range_generator: top level, front, queue and back joined
// depends on urrg_pkg, urrg_front, urrg_queue, urrg_back
//
// Takes one request per cycle while full is low and returns one result per
// request, in order. The seed update (one constant multiply-add) is done in the
// front as each request is taken, so requests may follow each other every cycle
// until the request queue fills. A result passes through the request queue and
// then the six-stage scaling pipeline (span, multiply, three adds, rounding and
// clamp). Seed loads and empty ranges take the same path.
module uniform_random_range_generator (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  urrg_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output urrg_pkg::res_t res
);
  import urrg_pkg::*;

  logic q_full;
  logic enq;
  job_t enq_job;
  logic deq;
  logic q_vld;
  job_t q_job;
  logic res_vld;

  urrg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .req    (req),
    .full   (full),
    .q_full (q_full),
    .enq    (enq),
    .job    (enq_job)
  );

  urrg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_job (enq_job),
    .q_full  (q_full),
    .deq     (deq),
    .q_vld   (q_vld),
    .q_job   (q_job)
  );

  urrg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_vld   (q_vld),
    .q_job   (q_job),
    .deq     (deq),
    .pop     (pop),
    .res_vld (res_vld),
    .res     (res)
  );

  assign empty = ~res_vld;

endmodule

[tb/uniform_random_range_generator_tb.sv]
// uniform_random_range_generator_tb: self-checking bench for the random range generator
// predicts every draw and seed from its own copy of the seed and compares each popped result
// depends on urrg_pkg and uniform_random_range_generator
module uniform_random_range_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urrg_pkg::*;

  localparam longint TWO31  = 64'sd2147483648;
  localparam longint SMAX32 = TWO31 - 64'sd1;
  localparam longint SMIN32 = -TWO31;
  localparam bit [63:0] MASK14 = 64'h3FFF;
  localparam bit [63:0] MASK23 = 64'h7F_FFFF;
  localparam bit [63:0] MASK46 = 64'h3FFF_FFFF_FFFF;
  localparam bit [31:0] SEED_ZERO_SUB = 32'd259341593;
  localparam bit [31:0] LCG_MULT = 32'd69069;
  localparam int RANDOM_REQS = 800;
  localparam int QUIET_TAIL  = 150;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  res_t res;

  bit [31:0] gen_seed;
  res_t pending_draws[$];
  int err_count;
  int draws_checked;
  int cmd_count[4];
  bit no_idle;
  int pop_hold;

  uniform_random_range_generator i_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (req),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit [31:0] advance_gen_seed();
    bit [31:0] s;
    s = (gen_seed == 32'd0) ? SEED_ZERO_SUB : gen_seed;
    s = s * LCG_MULT + 32'd1;
    gen_seed = s;
    return s;
  endfunction

  function automatic longint scale_span(bit [63:0] span, bit [31:0] s, output bit [63:0] rem);
    bit [63:0] m, x, y, sum;
    m = {41'b0, s[31:9]};
    x = span * (m + 64'd1);
    y = span * m;
    sum = ((x & MASK23) << 23) + y;
    rem = sum & MASK46;
    return longint'((x >> 23) + (sum >> 46));
  endfunction

  // negative values with no fraction bits step down by one
  function automatic longint round_down(longint ip, bit [63:0] frac);
    if (ip < 0 && frac == 64'd0) return ip - 1;
    return ip;
  endfunction

  function automatic longint draw_in_range(longint lo_b, longint hi_b);
    longint q, i, e1, s1;
    bit [63:0] rem, f, m, span;
    bit [31:0] s;
    if (lo_b >= hi_b) return lo_b;
    if (hi_b != SMAX32) begin
      e1 = hi_b + 1;
      s = advance_gen_seed();
      span = e1 - lo_b;
      q = scale_span(span, s, rem);
      i = round_down(q + lo_b, rem);
      if (i < lo_b) i = lo_b;
      if (i >= e1) i = e1 - 1;
    end else if (lo_b != SMIN32) begin
      s1 = lo_b - 1;
      s = advance_gen_seed();
      span = hi_b - s1;
      q = scale_span(span, s, rem);
      i = round_down(q + s1 + 1, rem);
      if (i <= s1) i = s1 + 1;
      if (i > hi_b) i = hi_b;
    end else begin
      s = advance_gen_seed();
      m = {41'b0, s[31:9]};
      f = ((m + 64'd1) << 23) + m;
      i = round_down(longint'(f >> 14) - TWO31, f & MASK14);
    end
    return i;
  endfunction

  function automatic res_t predict_result(req_t r);
    res_t o;
    bit [31:0] hi_u, lo_u;
    longint r64;
    o.value = '0;
    case (cmd_e'(r.cmd))
      CMD_LOAD: begin
        gen_seed = r.operand_a;
      end
      CMD_FULL: begin
        o.value = 32'(draw_in_range(SMIN32, SMAX32));
      end
      CMD_SIGNED: begin
        o.value = 32'(draw_in_range(longint'(int'(r.operand_a)), longint'(int'(r.operand_b))));
      end
      default: begin
        hi_u = r.operand_a;
        lo_u = r.operand_b;
        if (hi_u < lo_u) begin
          hi_u = r.operand_b;
          lo_u = r.operand_a;
        end
        r64 = draw_in_range(longint'({32'b0, lo_u}) - TWO31, longint'({32'b0, hi_u}) - TWO31);
        o.value = 32'(r64 + TWO31);
      end
    endcase
    o.seed_out = gen_seed;
    return o;
  endfunction

  function automatic req_t mk_req(cmd_e c, bit [31:0] a, bit [31:0] b);
    req_t r;
    r.cmd = c;
    r.operand_a = a;
    r.operand_b = b;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    req <= r;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_draws.push_back(predict_result(r));
    cmd_count[r.cmd]++;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_draw(input res_t got);
    res_t want;
    if (pending_draws.size() == 0) begin
      $display("%0t: result %h with no request outstanding", $time, got);
      err_count++;
      return;
    end
    want = pending_draws.pop_front();
    draws_checked++;
    if (got.value !== want.value) begin
      $display("%0t: value expected %h actual %h", $time, want.value, got.value);
      err_count++;
    end
    if (got.seed_out !== want.seed_out) begin
      $display("%0t: seed_out expected %h actual %h", $time, want.seed_out, got.seed_out);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else begin
      if (pop && !empty) check_draw(res);
      if (!no_idle && pop_hold == 0 && $urandom_range(0, 4) == 0) pop_hold = $urandom_range(1, 4);
      if (pop_hold != 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // zero seed substitution and empty ranges leaving the seed alone
  task automatic test_seed_load();
    send_req(mk_req(CMD_LOAD, 32'd0, 32'hFFFF_FFFF));
    send_req(mk_req(CMD_FULL, 32'd0, 32'd0));
    send_req(mk_req(CMD_LOAD, 32'hFFFF_FFFF, 32'd0));
    send_req(mk_req(CMD_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(mk_req(CMD_LOAD, 32'd0, 32'd0));
    send_req(mk_req(CMD_SIGNED, 32'd5, 32'd5));
    send_req(mk_req(CMD_SIGNED, 32'd7, 32'd3));
    send_req(mk_req(CMD_FULL, 32'd0, 32'd0));
  endtask

  task automatic test_full_range();
    send_req(mk_req(CMD_LOAD, 32'd1, 32'd0));
    send_req(mk_req(CMD_FULL, 32'd0, 32'd0));
    send_req(mk_req(CMD_FULL, 32'd0, 32'd0));
  endtask

  task automatic test_signed_range();
    send_req(mk_req(CMD_SIGNED, 32'h8000_0000, 32'h7FFF_FFFF));
    send_req(mk_req(CMD_SIGNED, 32'd0, 32'h7FFF_FFFF));
    send_req(mk_req(CMD_SIGNED, 32'h8000_0000, 32'h8000_0001));
    send_req(mk_req(CMD_SIGNED, -32'sd5, 32'd5));
    send_req(mk_req(CMD_SIGNED, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
    send_req(mk_req(CMD_SIGNED, -32'sd100, -32'sd90));
    send_req(mk_req(CMD_SIGNED, 32'h8000_0000, 32'hFFFF_FFFF));
  endtask

  task automatic test_unsigned_range();
    send_req(mk_req(CMD_UNSIGNED, 32'd0, 32'hFFFF_FFFF));
    send_req(mk_req(CMD_UNSIGNED, 32'hFFFF_FFFF, 32'd0));
    send_req(mk_req(CMD_UNSIGNED, 32'hFFFF_FFFF, 32'd1));
    send_req(mk_req(CMD_UNSIGNED, 32'd10, 32'd20));
    send_req(mk_req(CMD_UNSIGNED, 32'd42, 32'd42));
    send_req(mk_req(CMD_UNSIGNED, 32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  function automatic bit [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'h7FFF_FFFF - $urandom_range(0, 15);
      3: return 32'h8000_0000 + $urandom_range(0, 15);
      4: return $urandom_range(0, 15);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endcase
  endfunction

  task automatic test_random_mix();
    bit [31:0] a, b;
    cmd_e c;
    int pick;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS - QUIET_TAIL) no_idle = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 5) c = CMD_LOAD;
      else if (pick < 25) c = CMD_FULL;
      else if (pick < 62) c = CMD_SIGNED;
      else c = CMD_UNSIGNED;
      a = rand_operand();
      case ($urandom_range(0, 3))
        0: b = a + $urandom_range(0, 40);
        1: b = a - $urandom_range(0, 40);
        default: b = rand_operand();
      endcase
      if (c == CMD_LOAD && $urandom_range(0, 7) == 0) a = 32'd0;
      send_req(mk_req(c, a, b));
    end
  endtask

  initial begin
    gen_seed = 32'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_seed_load();
    test_full_range();
    test_signed_range();
    test_unsigned_range();
    test_random_mix();
    push <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("checked %0d results from %0d seed loads, %0d full-range draws,",
             draws_checked, cmd_count[CMD_LOAD], cmd_count[CMD_FULL]);
    $display("%0d signed range draws and %0d unsigned range draws",
             cmd_count[CMD_SIGNED], cmd_count[CMD_UNSIGNED]);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/urrg_pkg.sv
sv/urrg_front.sv
sv/urrg_queue.sv
sv/urrg_back.sv
sv/uniform_random_range_generator.sv
tb/uniform_random_range_generator_tb.sv
